// ===== rtl/core/rwc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rwc_pkg;

	localparam int PIX_W    = 16;
	localparam int COEF_W   = 16;
	localparam int POS_W    = 20;
	localparam int OP_W     = 2;
	localparam int CIDX_W   = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int PROD_W   = PIX_W + COEF_W;
	localparam int FRAC_SHIFT = 12;

	// opcodes of an input item
	localparam logic [OP_W-1:0] OP_COEF  = 2'd0;
	localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
	localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;

	// saturation limits, Q2.14
	localparam logic [PIX_W-1:0] SAT_HI = 16'h4000;
	localparam logic [PIX_W-1:0] SAT_LO = 16'hC000;

	// result queue
	localparam int RQ_DEPTH = 8;
	localparam int RQ_PTR_W = 3;

	typedef struct packed {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		pixel_t           pix;
		logic [POS_W-1:0] pos;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/core/rwc_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface rwc_in_if;
	import rwc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           opcode;
	logic [CIDX_W-1:0]         coef_index;
	logic signed [COEF_W-1:0]  coef_value;
	logic signed [PIX_W-1:0]   pixel_blue;
	logic signed [PIX_W-1:0]   pixel_green;
	logic signed [PIX_W-1:0]   pixel_red;
	modport source (output valid, opcode, coef_index, coef_value,
		pixel_blue, pixel_green, pixel_red, input ready);
	modport sink (input valid, opcode, coef_index, coef_value,
		pixel_blue, pixel_green, pixel_red, output ready);
endinterface

interface rwc_out_if;
	import rwc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [PIX_W-1:0]  out_blue;
	logic signed [PIX_W-1:0]  out_green;
	logic signed [PIX_W-1:0]  out_red;
	logic [POS_W-1:0]         out_position;
	modport source (output valid, out_blue, out_green, out_red, out_position,
		input ready);
	modport sink (input valid, out_blue, out_green, out_red, out_position,
		output ready);
endinterface

interface rwc_cfg_if;
	import rwc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rgb_window_convolution_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RGB window convolution: takes one item per clock while ready (coefficient
// load, raster pixel or flush) and filters each color channel of a pixel
// stream with one square kernel of side 2*radius+1, Q4.12 coefficients in
// row-major order, exact sums saturated to -1..+1 in Q2.14. Pixels nearer an
// edge than the radius pass through. A pixel's result appears with the item
// that brings the pixel radius rows plus radius pixels later; flush items
// drain the tail of an image, one result each. The row buffer is one memory
// of MAX_WIDTH columns, each entry holding the column's pixel in all
// 2*MAX_RADIUS+1 row slots, written once and read twice (feed column,
// pass-through pixel) per cycle; all kernel taps multiply in parallel.
// Sustained rate is one item per cycle while input ready is high; a result
// passes stages 1 to 5 into an eight-entry result queue, and input ready
// drops only while that queue plus the results in flight fill its eight
// places. Config writes are always taken; indexes 0 to 2 restart the frame.
module rgb_window_convolution_unit #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024,
	parameter int MAX_RADIUS = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	rwc_in_if.sink    pixels,
	rwc_out_if.source results,
	rwc_cfg_if.sink   cfg
);
	import rwc_pkg::*;

	localparam int S         = 2 * MAX_RADIUS + 1;    // row slots and window side
	localparam int C         = MAX_RADIUS;            // window center
	localparam int KSIZE     = S * S;
	localparam int KIDX_W    = $clog2(KSIZE);
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int WID_W     = $clog2(MAX_WIDTH + 1);
	localparam int HGT_W     = $clog2(MAX_HEIGHT + 1);
	localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
	localparam int SLOT_W    = $clog2(S);
	localparam int ROW_W     = PROD_W + $clog2(S);
	localparam int ACC_W     = ROW_W + $clog2(S);

	localparam logic signed [ACC_W-1:0] SAT_LIM  = ACC_W'(67108864);
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(2048);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(S - 1);

	// configuration, held clamped
	logic [WID_W-1:0] w_q;
	logic [HGT_W-1:0] h_q;
	logic [RAD_W-1:0] r_q;

	// frame counters
	logic [COL_W-1:0]  in_col_q;
	logic [HGT_W-1:0]  in_row_q;
	logic [SLOT_W-1:0] in_slot_q;
	logic [COL_W-1:0]  out_x_q;
	logic [HGT_W-1:0]  out_y_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [POS_W-1:0]  out_pos_q;

	// storage
	pixel_t           row_mem [MAX_WIDTH][S];
	logic [COEF_W-1:0] coef_q [KSIZE];
	pixel_t           window_q [S][S];      // [column][row slot], newest column last

	// result queue and credits
	result_t               rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0]   rq_wr_q, rq_rd_q;
	logic [RQ_PTR_W:0]     rq_fill_q;
	logic [RQ_PTR_W:0]     credit_q;

	logic in_acc, out_acc, cfg_acc, cfg_hit;
	logic pix_acc, coef_acc, fl_acc;

	assign pixels.ready = (credit_q < (RQ_PTR_W+1)'(RQ_DEPTH));
	assign cfg.ready    = 1'b1;
	assign in_acc  = pixels.valid && pixels.ready;
	assign out_acc = results.valid && results.ready;
	assign cfg_acc = cfg.valid && cfg.ready;
	assign cfg_hit = cfg_acc && ((cfg.index == REG_IMAGE_WIDTH) ||
		(cfg.index == REG_IMAGE_HEIGHT) || (cfg.index == REG_WINDOW_RADIUS));
	assign pix_acc  = in_acc && (pixels.opcode == OP_PIXEL);
	assign coef_acc = in_acc && (pixels.opcode == OP_COEF);
	assign fl_acc   = in_acc && (pixels.opcode == OP_FLUSH);

	// ---------------- stage 0: counters, emit decision, memory access
	logic              restart;
	logic [COL_W-1:0]  col_e, ox_e;
	logic [HGT_W-1:0]  row_e, oy_e;
	logic [SLOT_W-1:0] slot_e, os_e;
	logic [POS_W-1:0]  pos_e;
	logic              px_emit, fl_emit, emit, at_edge;
	logic              ox_wrap, fl_done;
	pixel_t            in_pix;

	assign in_pix = '{red: pixels.pixel_red, green: pixels.pixel_green,
		blue: pixels.pixel_blue};

	always_comb begin
		// a pixel after a complete image starts a new one
		restart = pix_acc && (int'(in_row_q) >= int'(h_q));
		col_e  = restart ? '0 : in_col_q;
		row_e  = restart ? '0 : in_row_q;
		slot_e = restart ? '0 : in_slot_q;
		ox_e   = restart ? '0 : out_x_q;
		oy_e   = restart ? '0 : out_y_q;
		os_e   = restart ? '0 : out_slot_q;
		pos_e  = restart ? '0 : out_pos_q;
		px_emit = pix_acc && ((int'(row_e) > int'(r_q)) ||
			((int'(row_e) == int'(r_q)) && (int'(col_e) >= int'(r_q))));
		fl_emit = fl_acc && (int'(in_row_q) >= int'(h_q)) &&
			(int'(out_y_q) < int'(h_q));
		emit = px_emit || fl_emit;
		at_edge = (int'(ox_e) < int'(r_q)) || (int'(ox_e) + int'(r_q) >= int'(w_q)) ||
			(int'(oy_e) < int'(r_q)) || (int'(oy_e) + int'(r_q) >= int'(h_q));
		ox_wrap = (int'(ox_e) + 1 >= int'(w_q));
		fl_done = fl_emit && ox_wrap && (int'(oy_e) + 1 >= int'(h_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WID_W'(640);
			h_q <= HGT_W'(480);
			r_q <= RAD_W'(1);
		end else if (cfg_acc) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH: begin
					if (int'(cfg.data) < 3) w_q <= WID_W'(3);
					else if (int'(cfg.data) > MAX_WIDTH) w_q <= WID_W'(MAX_WIDTH);
					else w_q <= WID_W'(cfg.data);
				end
				REG_IMAGE_HEIGHT: begin
					if (int'(cfg.data) < 3) h_q <= HGT_W'(3);
					else if (int'(cfg.data) > MAX_HEIGHT) h_q <= HGT_W'(MAX_HEIGHT);
					else h_q <= HGT_W'(cfg.data);
				end
				REG_WINDOW_RADIUS: begin
					// the radius register is three bits wide
					if (int'(cfg.data[2:0]) < 1) r_q <= RAD_W'(1);
					else if (int'(cfg.data[2:0]) > MAX_RADIUS) r_q <= RAD_W'(MAX_RADIUS);
					else r_q <= RAD_W'(cfg.data[2:0]);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_slot_q <= '0;
			out_pos_q  <= '0;
		end else if (cfg_hit) begin
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_slot_q <= '0;
			out_pos_q  <= '0;
		end else if (fl_done) begin
			// image fully drained
			in_col_q   <= '0;
			in_row_q   <= '0;
			in_slot_q  <= '0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_slot_q <= '0;
			out_pos_q  <= '0;
		end else begin
			if (pix_acc) begin
				if (int'(col_e) + 1 >= int'(w_q)) begin
					in_col_q  <= '0;
					in_row_q  <= row_e + 1'b1;
					in_slot_q <= (slot_e == SLOT_LAST) ? '0 : slot_e + 1'b1;
				end else begin
					in_col_q  <= col_e + 1'b1;
					in_row_q  <= row_e;
					in_slot_q <= slot_e;
				end
			end
			if (emit) begin
				out_pos_q <= pos_e + 1'b1;
				if (ox_wrap) begin
					out_x_q    <= '0;
					out_y_q    <= oy_e + 1'b1;
					out_slot_q <= (os_e == SLOT_LAST) ? '0 : os_e + 1'b1;
				end else begin
					out_x_q    <= ox_e + 1'b1;
					out_y_q    <= oy_e;
					out_slot_q <= os_e;
				end
			end else if (restart) begin
				out_x_q    <= '0;
				out_y_q    <= '0;
				out_slot_q <= '0;
				out_pos_q  <= '0;
			end
		end
	end

	// kernel coefficients: a load passes a register before it is written, so
	// that results accepted before it still multiply with the old kernel
	logic              coef_wr_s1;
	logic [KIDX_W-1:0] coef_idx_s1;
	logic [COEF_W-1:0] coef_val_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) coef_wr_s1 <= 1'b0;
		else coef_wr_s1 <= coef_acc && (int'(pixels.coef_index) < KSIZE);
	end

	always_ff @(posedge clk) begin
		coef_idx_s1 <= pixels.coef_index[KIDX_W-1:0];
		coef_val_s1 <= pixels.coef_value;
		if (coef_wr_s1)
			coef_q[coef_idx_s1] <= coef_val_s1;
	end

	// ---------------- stage 1: row buffer read data
	pixel_t            feed_s1 [S];
	pixel_t            ctr_row_s1 [S];
	logic              v_s1, shift_s1, edge_s1;
	logic [SLOT_W-1:0] fwd_slot_s1, os_s1;
	pixel_t            fwd_pix_s1;
	logic [POS_W-1:0]  pos_s1;

	always_ff @(posedge clk) begin
		if (pix_acc)
			row_mem[col_e][slot_e] <= in_pix;
		feed_s1    <= row_mem[col_e];
		ctr_row_s1 <= row_mem[ox_e];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			shift_s1 <= 1'b0;
		end else begin
			v_s1     <= emit;
			shift_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		fwd_slot_s1 <= slot_e;
		fwd_pix_s1  <= in_pix;
		os_s1       <= os_e;
		edge_s1     <= at_edge;
		pos_s1      <= pos_e;
	end

	// feed column: the incoming pixel replaces its own row slot
	always_ff @(posedge clk) begin
		if (shift_s1) begin
			for (int k = 0; k < S - 1; k++)
				window_q[k] <= window_q[k+1];
			for (int s = 0; s < S; s++)
				window_q[S-1][s] <= (SLOT_W'(s) == fwd_slot_s1) ? fwd_pix_s1 : feed_s1[s];
		end
	end

	// ---------------- stage 2: window aligned to this result
	logic              v_s2, edge_s2;
	logic [SLOT_W-1:0] ys_s2;
	pixel_t            ctr_s2;
	logic [POS_W-1:0]  pos_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		edge_s2 <= edge_s1;
		ys_s2   <= os_s1;
		ctr_s2  <= ctr_row_s1[os_s1];
		pos_s2  <= pos_s1;
	end

	logic [SLOT_W-1:0] row_slot [S];
	logic [COEF_W-1:0] tap_coef [S][S];
	pixel_t            tap_pix  [S][S];

	always_comb begin
		for (int i = 0; i < S; i++) begin
			int v;
			v = int'(ys_s2) + i - C;
			if (v < 0) v = v + S;
			else if (v >= S) v = v - S;
			row_slot[i] = SLOT_W'(v);
		end
	end

	// taps outside the current radius weigh zero
	always_comb begin
		for (int i = 0; i < S; i++) begin
			for (int j = 0; j < S; j++) begin
				tap_coef[i][j] = '0;
				tap_pix[i][j]  = '0;
				for (int rr = 1; rr <= MAX_RADIUS; rr++) begin
					if ((int'(r_q) == rr) && (i >= C - rr) && (i <= C + rr) &&
						(j >= C - rr) && (j <= C + rr)) begin
						tap_coef[i][j] = coef_q[(i - C + rr) * (2 * rr + 1) + (j - C + rr)];
						tap_pix[i][j]  = window_q[j + C - rr][row_slot[i]];
					end
				end
			end
		end
	end

	// ---------------- stage 3: products
	logic signed [PROD_W-1:0] prod_b_s3 [S][S];
	logic signed [PROD_W-1:0] prod_g_s3 [S][S];
	logic signed [PROD_W-1:0] prod_r_s3 [S][S];
	logic              v_s3, edge_s3;
	pixel_t            ctr_s3;
	logic [POS_W-1:0]  pos_s3;

	always_ff @(posedge clk) begin
		for (int i = 0; i < S; i++) begin
			for (int j = 0; j < S; j++) begin
				prod_b_s3[i][j] <= $signed(tap_coef[i][j]) * $signed(tap_pix[i][j].blue);
				prod_g_s3[i][j] <= $signed(tap_coef[i][j]) * $signed(tap_pix[i][j].green);
				prod_r_s3[i][j] <= $signed(tap_coef[i][j]) * $signed(tap_pix[i][j].red);
			end
		end
		edge_s3 <= edge_s2;
		ctr_s3  <= ctr_s2;
		pos_s3  <= pos_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else v_s3 <= v_s2;
	end

	// ---------------- stage 4: per-row sums
	logic signed [ROW_W-1:0] row_b_s4 [S];
	logic signed [ROW_W-1:0] row_g_s4 [S];
	logic signed [ROW_W-1:0] row_r_s4 [S];
	logic              v_s4, edge_s4;
	pixel_t            ctr_s4;
	logic [POS_W-1:0]  pos_s4;

	always_ff @(posedge clk) begin
		for (int i = 0; i < S; i++) begin
			logic signed [ROW_W-1:0] sb, sg, sr;
			sb = '0;
			sg = '0;
			sr = '0;
			for (int j = 0; j < S; j++) begin
				sb = sb + ROW_W'(prod_b_s3[i][j]);
				sg = sg + ROW_W'(prod_g_s3[i][j]);
				sr = sr + ROW_W'(prod_r_s3[i][j]);
			end
			row_b_s4[i] <= sb;
			row_g_s4[i] <= sg;
			row_r_s4[i] <= sr;
		end
		edge_s4 <= edge_s3;
		ctr_s4  <= ctr_s3;
		pos_s4  <= pos_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else v_s4 <= v_s3;
	end

	// ---------------- stage 5: window sums
	logic signed [ACC_W-1:0] acc_b_s5, acc_g_s5, acc_r_s5;
	logic              v_s5, edge_s5;
	pixel_t            ctr_s5;
	logic [POS_W-1:0]  pos_s5;

	always_ff @(posedge clk) begin
		logic signed [ACC_W-1:0] sb, sg, sr;
		sb = '0;
		sg = '0;
		sr = '0;
		for (int i = 0; i < S; i++) begin
			sb = sb + ACC_W'(row_b_s4[i]);
			sg = sg + ACC_W'(row_g_s4[i]);
			sr = sr + ACC_W'(row_r_s4[i]);
		end
		acc_b_s5 <= sb;
		acc_g_s5 <= sg;
		acc_r_s5 <= sr;
		edge_s5  <= edge_s4;
		ctr_s5   <= ctr_s4;
		pos_s5   <= pos_s4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else v_s5 <= v_s4;
	end

	// ---------------- saturation and pass-through, into the result queue
	function automatic logic [PIX_W-1:0] sat_round(input logic signed [ACC_W-1:0] s);
		logic signed [ACC_W-1:0] t;
		t = (s + RND_BIAS) >>> FRAC_SHIFT;
		if (s > SAT_LIM) return SAT_HI;
		else if (s < -SAT_LIM) return SAT_LO;
		else return t[PIX_W-1:0];
	endfunction

	result_t res_d;

	always_comb begin
		res_d.pos = pos_s5;
		if (edge_s5) begin
			res_d.pix = ctr_s5;
		end else begin
			res_d.pix.blue  = sat_round(acc_b_s5);
			res_d.pix.green = sat_round(acc_g_s5);
			res_d.pix.red   = sat_round(acc_r_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s5)
			rq_q[rq_wr_q] <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q   <= '0;
			rq_rd_q   <= '0;
			rq_fill_q <= '0;
			credit_q  <= '0;
		end else begin
			if (v_s5) rq_wr_q <= rq_wr_q + 1'b1;
			if (out_acc) rq_rd_q <= rq_rd_q + 1'b1;
			rq_fill_q <= rq_fill_q + (RQ_PTR_W+1)'(v_s5) - (RQ_PTR_W+1)'(out_acc);
			// credit covers results in flight plus those queued
			credit_q  <= credit_q + (RQ_PTR_W+1)'(in_acc && emit) - (RQ_PTR_W+1)'(out_acc);
		end
	end

	assign results.valid        = (rq_fill_q != '0);
	assign results.out_blue     = rq_q[rq_rd_q].pix.blue;
	assign results.out_green    = rq_q[rq_rd_q].pix.green;
	assign results.out_red      = rq_q[rq_rd_q].pix.red;
	assign results.out_position = rq_q[rq_rd_q].pos;

endmodule

`default_nettype wire

// ===== rtl/core/rwc_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rwc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [67:0] out_data
);

	// a waiting result holds until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_data))
		else $error("stalled result changed");

	// with nothing queued the input side never backs up
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result queue");

	// no result leaves right out of reset
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result present after reset");

endmodule

bind rgb_window_convolution_unit rwc_checker u_rwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (pixels.ready),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  ({results.out_blue, results.out_green, results.out_red,
		results.out_position})
);

`default_nettype wire

// ===== test/rgb_window_convolution_unit_test.sv =====
`timescale 1ns / 1ps

// checks the rgb window convolution unit against an in-bench model of the
// line-buffered filter: every accepted item is run through the model and the
// expected result, if any, is queued; results leaving the unit are compared
// in order, field by field
module rgb_window_convolution_unit_test;
	import rwc_pkg::*;

	localparam int MAX_W      = 1024;
	localparam int MAX_H      = 1024;
	localparam int MAX_R      = 4;
	localparam int SLOTS      = 2 * MAX_R + 1;
	localparam int TAPS       = SLOTS * SLOTS;
	localparam int SETTLE     = 24;
	localparam int CYCLE_CAP  = 600000;
	localparam int RAND_ITEMS = 400;

	typedef struct {
		logic [OP_W-1:0]   op;
		logic [CIDX_W-1:0] idx;
		logic [15:0]       coef;
		logic [15:0]       blue;
		logic [15:0]       green;
		logic [15:0]       red;
	} stim_t;

	typedef struct {
		logic [15:0]      blue;
		logic [15:0]      green;
		logic [15:0]      red;
		logic [POS_W-1:0] pos;
	} filt_t;

	// directed row: an item plus an optional expectation typed by hand
	typedef struct {
		stim_t s;
		bit    typed;
		filt_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	rwc_in_if  pixels();
	rwc_out_if results();
	rwc_cfg_if cfg();

	rgb_window_convolution_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixels (pixels.sink),
		.results(results.source),
		.cfg    (cfg.sink)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model state: row slots, kernel, raster counters and registers
	logic signed [15:0] line_mem [0:SLOTS*MAX_W-1][0:2];
	int                 kernel [0:TAPS-1];
	int unsigned        col_cnt, row_cnt, emit_cnt;
	int unsigned        width_reg, height_reg, radius_reg;

	filt_t       pending_q[$];
	int          mismatches = 0;
	int unsigned cycles = 0;
	int          burst_left = 0;
	int          rand_sent = 0;

	function automatic int unsigned clampu(int unsigned v, int unsigned lo, int unsigned hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic int unsigned cur_w();
		return clampu(width_reg, 3, MAX_W);
	endfunction
	function automatic int unsigned cur_h();
		return clampu(height_reg, 3, MAX_H);
	endfunction
	function automatic int unsigned cur_r();
		return clampu(radius_reg, 1, MAX_R);
	endfunction

	// exact sum saturated to -1..+1, rounded half up
	function automatic logic [15:0] saturate(longint s);
		longint lim;
		lim = longint'(1) << 26;
		if (s > lim) return SAT_HI;
		if (s < -lim) return SAT_LO;
		return 16'(((s + lim + 2048) >>> 12) - 16384);
	endfunction

	// filter output for raster index p of the current image
	function automatic filt_t filter_at(int unsigned p);
		int unsigned w, h, r, x, y, side, base;
		longint      acc [0:2];
		filt_t       f;
		w = cur_w(); h = cur_h(); r = cur_r();
		x = p % w; y = p / w; side = 2 * r + 1;
		f.pos = POS_W'(p);
		if (x < r || x + r >= w || y < r || y + r >= h) begin
			base = (y % SLOTS) * MAX_W + x;
			f.blue = line_mem[base][0];
			f.green = line_mem[base][1];
			f.red = line_mem[base][2];
			return f;
		end
		acc = '{0, 0, 0};
		for (int ky = 0; ky < side; ky++) begin
			for (int kx = 0; kx < side; kx++) begin
				base = ((y - r + ky) % SLOTS) * MAX_W + x - r + kx;
				for (int c = 0; c < 3; c++)
					acc[c] += longint'(kernel[ky * side + kx]) * longint'(line_mem[base][c]);
			end
		end
		f.blue = saturate(acc[0]);
		f.green = saturate(acc[1]);
		f.red = saturate(acc[2]);
		return f;
	endfunction

	function automatic void restart_image();
		col_cnt = 0; row_cnt = 0; emit_cnt = 0;
	endfunction

	// advance the model by one accepted item; returns 1 with a result
	function automatic bit model_step(stim_t s, output filt_t f);
		int unsigned w, h, r, q, base;
		w = cur_w(); h = cur_h(); r = cur_r();
		case (s.op)
			OP_COEF: begin
				if (s.idx < TAPS) kernel[s.idx] = int'($signed(s.coef));
				return 0;
			end
			OP_PIXEL: begin
				if (row_cnt >= h) restart_image();
				base = (row_cnt % SLOTS) * MAX_W + col_cnt;
				line_mem[base][0] = s.blue;
				line_mem[base][1] = s.green;
				line_mem[base][2] = s.red;
				q = row_cnt * w + col_cnt;
				col_cnt++;
				if (col_cnt >= w) begin
					col_cnt = 0;
					row_cnt++;
				end
				if (q >= r * w + r) begin
					f = filter_at(emit_cnt);
					emit_cnt++;
					return 1;
				end
				return 0;
			end
			OP_FLUSH: begin
				if (row_cnt >= h && emit_cnt < w * h) begin
					f = filter_at(emit_cnt);
					emit_cnt++;
					if (emit_cnt >= w * h) restart_image();
					return 1;
				end
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	// push one item through the input channel in bursts with random gaps;
	// a typed expectation replaces the model's one
	task automatic send_item(stim_t s, bit typed = 0, filt_t want = '{default: '0});
		bit    ok;
		bit    got;
		filt_t f;
		if (burst_left == 0) begin
			int gap;
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				pixels.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		burst_left--;
		pixels.valid <= 1'b1;
		pixels.opcode <= s.op;
		pixels.coef_index <= s.idx;
		pixels.coef_value <= s.coef;
		pixels.pixel_blue <= s.blue;
		pixels.pixel_green <= s.green;
		pixels.pixel_red <= s.red;
		// ready is sampled mid-cycle, where it holds its value for the edge
		do begin
			@(negedge clk);
			ok = pixels.ready;
			@(posedge clk);
		end while (!ok);
		got = model_step(s, f);
		if (got) pending_q.push_back(typed ? want : f);
	endtask

	// drop valid and let the unit drain before touching registers
	task automatic wait_idle();
		pixels.valid <= 1'b0;
		burst_left = 0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(logic [10:0] w, logic [10:0] h, logic [10:0] r);
		logic [CFG_IDX_W-1:0] idx [0:2];
		logic [10:0]          val [0:2];
		bit                   ok;
		idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_WINDOW_RADIUS};
		val = '{w, h, r};
		for (int i = 0; i < 3; i++) begin
			cfg.valid <= 1'b1;
			cfg.index <= idx[i];
			cfg.data <= val[i];
			do begin
				@(negedge clk);
				ok = cfg.ready;
				@(posedge clk);
			end while (!ok);
			case (idx[i])
				REG_IMAGE_WIDTH:  width_reg = val[i];
				REG_IMAGE_HEIGHT: height_reg = val[i];
				default:          radius_reg = val[i] & 11'h7;
			endcase
			restart_image();
		end
		cfg.valid <= 1'b0;
	endtask

	// mostly legal samples, now and then any bit pattern
	function automatic logic [15:0] rand_sample();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? SAT_HI : SAT_LO;
		return 16'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic stim_t pixel_item(logic [15:0] b, logic [15:0] g, logic [15:0] r);
		return '{op: OP_PIXEL, idx: 7'($urandom), coef: 16'($urandom),
			blue: b, green: g, red: r};
	endfunction

	function automatic stim_t rand_pixel();
		return pixel_item(rand_sample(), rand_sample(), rand_sample());
	endfunction

	function automatic stim_t flush_item();
		stim_t s;
		s = rand_pixel();
		s.op = OP_FLUSH;
		return s;
	endfunction

	// coefficient by profile: wide, mild or unit center
	function automatic logic [15:0] rand_coef(int profile, int tap, int side);
		case (profile)
			0:       return 16'($urandom);
			1:       return 16'($urandom_range(0, 1200) - 600);
			default: return (tap == (side * side) / 2) ? 16'h1000
				: 16'($urandom_range(0, 200) - 100);
		endcase
	endfunction

	task automatic load_kernel(int profile);
		int side;
		side = 2 * cur_r() + 1;
		for (int t = 0; t < TAPS; t++)
			send_item('{op: OP_COEF, idx: CIDX_W'(t),
				coef: rand_coef(profile, t, side), blue: '0, green: '0, red: '0});
	endtask

	// ignored items: unused opcode or coefficient index past the kernel
	function automatic stim_t noise_item();
		stim_t s;
		s = rand_pixel();
		if ($urandom_range(0, 1) == 0) s.op = 2'd3;
		else begin
			s.op = OP_COEF;
			s.idx = CIDX_W'($urandom_range(TAPS, 127));
		end
		return s;
	endfunction

	// one image, optionally cut short; only a complete one gets flushes (full or partial)
	task automatic run_image(int n_pix, bit count_it);
		int unsigned total, left;
		total = cur_w() * cur_h();
		for (int i = 0; i < n_pix; i++) begin
			int pick;
			pick = $urandom_range(0, 99);
			if (pick < 3) send_item(noise_item());
			else if (pick < 5)
				send_item('{op: OP_COEF, idx: CIDX_W'($urandom_range(0, TAPS - 1)),
					coef: rand_coef(1, 0, 3), blue: '0, green: '0, red: '0});
			send_item(rand_pixel());
			if (count_it) rand_sent++;
		end
		if (n_pix < total) return;
		left = total - emit_cnt;
		// sometimes stop draining early so the next pixel drops the tail
		if ($urandom_range(0, 4) == 0) left = $urandom_range(0, left);
		else left += $urandom_range(0, 3);
		repeat (left) begin
			send_item(flush_item());
			if (count_it) rand_sent++;
		end
	endtask

	// receiver: always ready, lightly stalled or heavily stalled by turns
	always @(posedge clk) begin
		int mode;
		cycles <= cycles + 1;
		mode = (cycles / 500) % 3;
		case (mode)
			0:       results.ready <= 1'b1;
			1:       results.ready <= ($urandom_range(0, 3) != 0);
			default: results.ready <= ($urandom_range(0, 7) == 0);
		endcase
		if (cycles > CYCLE_CAP) begin
			$display("rgb_window_convolution_unit_test failed");
			$finish;
		end
	end

	// compare each accepted result with the oldest expectation
	always @(negedge clk) begin
		filt_t want;
		if (arst_n && results.valid && results.ready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result pos %0d", results.out_position);
			end else begin
				want = pending_q.pop_front();
				if (results.out_blue !== want.blue || results.out_green !== want.green
					|| results.out_red !== want.red || results.out_position !== want.pos) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp pos %0d b %h g %h r %h, got pos %0d b %h g %h r %h",
							want.pos, want.blue, want.green, want.red, results.out_position,
							results.out_blue, results.out_green, results.out_red);
				end
			end
		end
	end

	row_t directed [$];

	initial begin
		pixels.valid = 1'b0;
		pixels.opcode = OP_COEF;
		pixels.coef_index = '0;
		pixels.coef_value = '0;
		pixels.pixel_blue = '0;
		pixels.pixel_green = '0;
		pixels.pixel_red = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_IMAGE_WIDTH;
		cfg.data = '0;
		for (int i = 0; i < SLOTS * MAX_W; i++) line_mem[i] = '{0, 0, 0};
		kernel = '{default: 0};
		width_reg = 640; height_reg = 480; radius_reg = 1;
		restart_image();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// a few pixels under the reset geometry, too few to produce results
		repeat (5) send_item(rand_pixel());

		// every tap written before any window is filtered
		load_kernel(0);
		wait_idle();
		// zero values clamp to a 3x3 image with radius 1
		write_regs(11'd0, 11'd0, 11'd0);

		// edge pixels of a 3x3 image pass straight through
		directed = '{
			'{'{OP_COEF, 7'd127, 16'h7FFF, 16'h0, 16'h0, 16'h0}, 0, '{default: '0}},
			'{'{2'd3, 7'd0, 16'h0, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 0, '{default: '0}},
			'{'{OP_FLUSH, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0}, 0, '{default: '0}},
			'{'{OP_PIXEL, 7'd0, 16'h0, SAT_HI, SAT_LO, 16'h7FFF}, 0, '{default: '0}},
			'{'{OP_PIXEL, 7'd0, 16'h0, SAT_LO, SAT_HI, 16'h8000}, 0, '{default: '0}},
			'{'{OP_PIXEL, 7'd0, 16'h0, 16'h0, 16'hFFFF, 16'h0001}, 0, '{default: '0}},
			'{'{OP_PIXEL, 7'd0, 16'h0, 16'h1234, 16'h0, 16'h0}, 0, '{default: '0}},
			'{'{OP_PIXEL, 7'd0, 16'h0, 16'h2000, 16'h2000, 16'h2000},
				1, '{SAT_HI, SAT_LO, 16'h7FFF, 20'd0}},
			'{'{OP_PIXEL, 7'd0, 16'h0, 16'hE000, 16'h1000, 16'h0100},
				1, '{SAT_LO, SAT_HI, 16'h8000, 20'd1}},
			'{'{OP_PIXEL, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0},
				1, '{16'h0, 16'hFFFF, 16'h0001, 20'd2}},
			'{'{OP_PIXEL, 7'd0, 16'h0, SAT_HI, SAT_HI, SAT_HI},
				1, '{16'h1234, 16'h0, 16'h0, 20'd3}},
			// center pixel goes through the kernel
			'{'{OP_PIXEL, 7'd0, 16'h0, SAT_LO, SAT_LO, SAT_LO}, 0, '{default: '0}},
			'{'{OP_FLUSH, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0},
				1, '{16'hE000, 16'h1000, 16'h0100, 20'd5}},
			'{'{OP_FLUSH, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0},
				1, '{16'h0, 16'h0, 16'h0, 20'd6}},
			'{'{OP_FLUSH, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0},
				1, '{SAT_HI, SAT_HI, SAT_HI, 20'd7}},
			'{'{OP_FLUSH, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0},
				1, '{SAT_LO, SAT_LO, SAT_LO, 20'd8}},
			// nothing left to drain
			'{'{OP_FLUSH, 7'd0, 16'h0, 16'h0, 16'h0, 16'h0}, 0, '{default: '0}},
			// extreme coefficients on the corner taps
			'{'{OP_COEF, 7'd0, 16'h7FFF, 16'h0, 16'h0, 16'h0}, 0, '{default: '0}},
			'{'{OP_COEF, 7'd80, 16'h8000, 16'h0, 16'h0, 16'h0}, 0, '{default: '0}}
		};
		foreach (directed[i]) send_item(directed[i].s, directed[i].typed, directed[i].want);

		// complete image and its drain, a spare flush, then a new image
		run_image(9, 0);
		send_item(flush_item());
		run_image(9, 0);

		// largest radius, clamped radius, window larger than the image
		wait_idle();
		write_regs(11'd9, 11'd9, 11'd4);
		load_kernel(1);
		run_image(81, 0);
		wait_idle();
		write_regs(11'd12, 11'd10, 11'd7);
		run_image(120, 0);
		wait_idle();
		write_regs(11'd5, 11'd4, 11'd3);
		run_image(20, 0);

		// random geometry and kernels, whole images mostly
		while (rand_sent < RAND_ITEMS) begin
			if ($urandom_range(0, 3) != 0) begin
				wait_idle();
				write_regs(11'($urandom_range(1, 14)), 11'($urandom_range(1, 12)),
					11'($urandom_range(0, 5)));
				if ($urandom_range(0, 1) == 0) load_kernel($urandom_range(0, 2));
			end
			run_image((cur_w() * cur_h() > 0 && $urandom_range(0, 9) == 0)
				? $urandom_range(1, cur_w() * cur_h()) : cur_w() * cur_h(), 1);
		end

		wait_idle();
		if (pending_q.size() != 0) mismatches++;
		if (mismatches == 0)
			$display("rgb_window_convolution_unit_test passed");
		else
			$display("rgb_window_convolution_unit_test failed");
		$finish;
	end

endmodule
